/* rtl/csvt_pkg.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Byte codes, token kinds and the token bundle shared by the tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] COMMA_BYTE = 8'h2C;

  localparam int unsigned MAX_TOKENS = 4;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;

  typedef struct packed {
    logic [MAX_TOKENS-1:0][1:0] kinds;
    logic [7:0]                 tok_byte;
    logic [2:0]                 cnt;
  } bundle_t;

endpackage

/* rtl/csv_stream_tokenizer.sv */
// ----------------------------------------------------------------------------
// CSV stream tokenizer
// A byte's tokens are registered into the output bundle, or into the pending
// bundle while the output is busy. Throughput: one byte per cycle while each byte
// yields at most one token and m_tready stays high; a byte with several tokens
// holds the output until all are taken, one with none takes no output slot.
// Reset (rst, synchronous): parser at field start, no row open, comma delimiter.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // is_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] token_byte
  output logic [1:0] m_tuser,   // [1:0] token_kind
  output logic       m_tlast,   // run_last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import csvt_pkg::*;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QUOTE_SEEN
  } mode_t;

  function automatic bundle_t push(bundle_t x, logic [1:0] kind);
    bundle_t y;
    y = x;
    y.kinds[x.cnt[1:0]] = kind;
    y.cnt = x.cnt + 3'd1;
    return y;
  endfunction

  logic [7:0] delimiter;
  mode_t      mode, mode_next;
  logic       row_open, row_open_next;
  logic       after_cr, after_cr_next;
  bundle_t    bnd;
  bundle_t    pend, outb;
  logic       pend_valid, out_valid;
  logic [1:0] idx;
  logic       accept, accept_any, out_take, out_last, out_done, out_free;
  logic [7:0] b;
  logic       eol;

  assign b   = s_tdata;
  assign eol = (b == CR_BYTE) || (b == LF_BYTE);

  always_comb begin
    mode_next     = mode;
    row_open_next = row_open;
    after_cr_next = 1'b0;
    bnd           = '0;
    bnd.tok_byte  = b;
    if (!(after_cr && b == LF_BYTE)) begin
      unique case (mode)
        MODE_START: begin
          if (eol) begin
            bnd = push(bnd, KIND_ROW_END);
            row_open_next = 1'b0;
            after_cr_next = (b == CR_BYTE);
          end else if (b == QUOTE_BYTE) begin
            mode_next = MODE_QUOTED;
            row_open_next = 1'b1;
          end else if (b == delimiter) begin
            bnd = push(bnd, KIND_FIELD_END);
            row_open_next = 1'b1;
          end else begin
            bnd = push(bnd, KIND_DATA);
            mode_next = MODE_PLAIN;
            row_open_next = 1'b1;
          end
        end
        MODE_PLAIN: begin
          if (b == delimiter) begin
            bnd = push(bnd, KIND_FIELD_END);
            mode_next = MODE_START;
          end else if (eol) begin
            bnd = push(bnd, KIND_FIELD_END);
            bnd = push(bnd, KIND_ROW_END);
            mode_next = MODE_START;
            row_open_next = 1'b0;
            after_cr_next = (b == CR_BYTE);
          end else begin
            bnd = push(bnd, KIND_DATA);
          end
        end
        MODE_QUOTED: begin
          if (b == QUOTE_BYTE) begin
            mode_next = MODE_QUOTE_SEEN;
          end else begin
            bnd = push(bnd, KIND_DATA);
          end
        end
        MODE_QUOTE_SEEN: begin
          if (b == QUOTE_BYTE) begin
            bnd = push(bnd, KIND_DATA);
            mode_next = MODE_QUOTED;
          end else begin
            bnd = push(bnd, KIND_FIELD_END);
            if (b == delimiter) begin
              mode_next = MODE_START;
            end else if (eol) begin
              bnd = push(bnd, KIND_ROW_END);
              mode_next = MODE_START;
              row_open_next = 1'b0;
              after_cr_next = (b == CR_BYTE);
            end else begin
              bnd = push(bnd, KIND_DATA);
              mode_next = MODE_PLAIN;
            end
          end
        end
        default: begin
          mode_next = MODE_START;
        end
      endcase
    end
    if (s_tlast) begin
      if (mode_next != MODE_START) begin
        bnd = push(bnd, KIND_FIELD_END);
      end
      if (row_open_next) begin
        bnd = push(bnd, KIND_ROW_END);
      end
      mode_next     = MODE_START;
      row_open_next = 1'b0;
      after_cr_next = 1'b0;
    end
  end

  assign s_tready   = !pend_valid;
  assign cfg_ready  = 1'b1;
  assign accept     = s_tvalid && s_tready;
  assign accept_any = accept && (bnd.cnt != 3'd0);
  assign out_take   = m_tvalid && m_tready;
  assign out_last   = ({1'b0, idx} + 3'd1) == outb.cnt;
  assign out_done   = out_take && out_last;
  assign out_free   = !out_valid || out_done;

  assign m_tvalid = out_valid;
  assign m_tuser  = outb.kinds[idx];
  assign m_tdata  = (outb.kinds[idx] == KIND_DATA) ? outb.tok_byte : 8'h00;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter  <= COMMA_BYTE;
      mode       <= MODE_START;
      row_open   <= 1'b0;
      after_cr   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delimiter <= cfg_data;
      end
      if (accept) begin
        mode     <= mode_next;
        row_open <= row_open_next;
        after_cr <= after_cr_next;
      end
      if (out_free) begin
        idx <= '0;
        if (pend_valid) begin
          outb       <= pend;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (accept_any) begin
          outb      <= bnd;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else begin
        if (out_take) begin
          idx <= idx + 2'd1;
        end
        if (accept_any) begin
          pend       <= bnd;
          pend_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid) else $error("pending bundle without output bundle");

  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outb.cnt != 3'd0 && {1'b0, idx} < outb.cnt))
    else $error("output index outside bundle");

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (mode == MODE_START && !row_open && !after_cr))
    else $error("parser state not cleared after final byte");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(idx)))
    else $error("output token advanced while stalled");
`endif

endmodule

/* tb/sv/tb_csv_stream_tokenizer.sv */
// ----------------------------------------------------------------------------
// CSV stream tokenizer testbench
// Streams CSV text into the tokenizer in random bursts while the token side
// stalls on a rotating pattern. A behavioral parser predicts the token
// stream for every accepted byte, and each token word is checked against
// it. The run covers directed corner cases and random texts under a range
// of delimiters, including NUL, 0xFF, quote, CR and LF.
// ----------------------------------------------------------------------------
module tb_csv_stream_tokenizer;
  import csvt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 20;

  typedef enum logic [1:0] {AT_START, IN_PLAIN, IN_QUOTED, QUOTE_SEEN} parse_st_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tbyte;
    logic       last;
  } token_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  byte_word_t  byte_q[$];
  token_t      token_q[$];
  int unsigned words_pushed = 0;
  int unsigned words_taken = 0;
  int unsigned tokens_checked = 0;
  int unsigned settings_used = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        word_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] rx_cyc = '0;
  logic [7:0]  gen_delim = COMMA_BYTE;

  parse_st_e   parse_st = AT_START;
  logic        row_open = 1'b0;
  logic        cr_pending = 1'b0;
  logic [7:0]  delim = COMMA_BYTE;

  logic [7:0]  phase_delims [8] = '{COMMA_BYTE, 8'h09, 8'h3B, 8'h00, 8'hFF,
                                    QUOTE_BYTE, CR_BYTE, LF_BYTE};

  csv_stream_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] data_byte
    .s_tlast   (s_tlast),   // is_final
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] token_byte
    .m_tuser   (m_tuser),   // [1:0] token_kind
    .m_tlast   (m_tlast),   // run_last
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic token_t mk_tok(logic [1:0] kind, logic [7:0] b);
    token_t t;
    t.kind = kind;
    t.tbyte = b;
    t.last = 1'b0;
    return t;
  endfunction

  task automatic tokenize_byte(input logic [7:0] b, input logic fin);
    token_t run[$];
    logic   eol;
    logic   row_done;
    eol = (b == CR_BYTE) || (b == LF_BYTE);
    row_done = 1'b0;
    if (cr_pending && b == LF_BYTE) begin
      cr_pending = 1'b0;
    end else begin
      cr_pending = 1'b0;
      case (parse_st)
        AT_START: begin
          if (eol) begin
            row_done = 1'b1;
          end else if (b == QUOTE_BYTE) begin
            parse_st = IN_QUOTED;
            row_open = 1'b1;
          end else if (b == delim) begin
            run.push_back(mk_tok(KIND_FIELD_END, 8'h00));
            row_open = 1'b1;
          end else begin
            run.push_back(mk_tok(KIND_DATA, b));
            parse_st = IN_PLAIN;
            row_open = 1'b1;
          end
        end
        IN_PLAIN: begin
          if (b == delim) begin
            run.push_back(mk_tok(KIND_FIELD_END, 8'h00));
            parse_st = AT_START;
          end else if (eol) begin
            run.push_back(mk_tok(KIND_FIELD_END, 8'h00));
            row_done = 1'b1;
          end else begin
            run.push_back(mk_tok(KIND_DATA, b));
          end
        end
        IN_QUOTED: begin
          if (b == QUOTE_BYTE) parse_st = QUOTE_SEEN;
          else run.push_back(mk_tok(KIND_DATA, b));
        end
        default: begin
          if (b == QUOTE_BYTE) begin
            run.push_back(mk_tok(KIND_DATA, QUOTE_BYTE));
            parse_st = IN_QUOTED;
          end else begin
            run.push_back(mk_tok(KIND_FIELD_END, 8'h00));
            if (b == delim) begin
              parse_st = AT_START;
            end else if (eol) begin
              row_done = 1'b1;
            end else begin
              run.push_back(mk_tok(KIND_DATA, b));
              parse_st = IN_PLAIN;
            end
          end
        end
      endcase
      if (row_done) begin
        run.push_back(mk_tok(KIND_ROW_END, 8'h00));
        parse_st = AT_START;
        row_open = 1'b0;
        cr_pending = (b == CR_BYTE);
      end
    end
    if (fin) begin
      if (parse_st != AT_START) run.push_back(mk_tok(KIND_FIELD_END, 8'h00));
      if (row_open) run.push_back(mk_tok(KIND_ROW_END, 8'h00));
      parse_st = AT_START;
      row_open = 1'b0;
      cr_pending = 1'b0;
    end
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) token_q.push_back(run[i]);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycles, token_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    token_t exp_tok;
    if (rst) begin
      word_taken <= 1'b0;
      parse_st = AT_START;
      row_open = 1'b0;
      cr_pending = 1'b0;
      delim = COMMA_BYTE;
    end else begin
      word_taken <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) delim = cfg_data;
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
        words_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token: expected none, got kind %0d byte %02h last %0b",
                   $time, m_tuser, m_tdata, m_tlast);
          errors++;
        end else begin
          exp_tok = token_q.pop_front();
          tokens_checked++;
          if (m_tuser !== exp_tok.kind) begin
            $display("%0t: token kind mismatch: expected %0d, got %0d",
                     $time, exp_tok.kind, m_tuser);
            errors++;
          end
          if (m_tdata !== exp_tok.tbyte) begin
            $display("%0t: token byte mismatch: expected %02h, got %02h",
                     $time, exp_tok.tbyte, m_tdata);
            errors++;
          end
          if (m_tlast !== exp_tok.last) begin
            $display("%0t: run end mismatch: expected %0b, got %0b",
                     $time, exp_tok.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : sender
    byte_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        w = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= w.data;
        s_tlast <= w.fin;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rx_cyc = rx_cyc + 1;
    case (rx_cyc[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= (rx_cyc % 3 != 0);
      2'd2: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (rx_cyc % 5 == 0);
    endcase
  end

  task automatic push_word(input logic [7:0] b, input logic fin);
    byte_word_t w;
    w.data = b;
    w.fin = fin;
    byte_q.push_back(w);
    words_pushed++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 122));
    end while (b == QUOTE_BYTE || b == CR_BYTE || b == LF_BYTE || b == gen_delim);
    return b;
  endfunction

  task automatic push_text(input int rows);
    int unsigned first;
    int          nf;
    int          len;
    first = words_pushed;
    for (int r = 0; r < rows; r++) begin
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) push_word(gen_delim, 1'b0);
        case ($urandom_range(0, 3))
          0: begin
          end
          1, 2: begin
            len = $urandom_range(1, 4);
            push_word(plain_byte(), 1'b0);
            for (int k = 1; k < len; k++)
              push_word(($urandom_range(0, 4) == 0) ? QUOTE_BYTE : plain_byte(), 1'b0);
          end
          default: begin
            push_word(QUOTE_BYTE, 1'b0);
            len = $urandom_range(0, 4);
            for (int k = 0; k < len; k++) begin
              case ($urandom_range(0, 5))
                0: push_word(gen_delim, 1'b0);
                1: push_word(CR_BYTE, 1'b0);
                2: push_word(LF_BYTE, 1'b0);
                3: begin
                  push_word(QUOTE_BYTE, 1'b0);
                  push_word(QUOTE_BYTE, 1'b0);
                end
                default: push_word(plain_byte(), 1'b0);
              endcase
            end
            push_word(QUOTE_BYTE, 1'b0);
          end
        endcase
      end
      case ($urandom_range(0, 4))
        0: push_word(CR_BYTE, 1'b0);
        1: push_word(LF_BYTE, 1'b0);
        2: begin
          push_word(CR_BYTE, 1'b0);
          push_word(LF_BYTE, 1'b0);
        end
        3: begin
          push_word(LF_BYTE, 1'b0);
          push_word(LF_BYTE, 1'b0);
        end
        default: if (r < rows - 1) push_word(LF_BYTE, 1'b0);
      endcase
    end
    if (words_pushed == first) push_word(LF_BYTE, 1'b0);
    byte_q[byte_q.size()-1].fin = 1'b1;
  endtask

  task automatic push_noise(input int cnt);
    logic [7:0] b;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 5))
        0: b = gen_delim;
        1: b = QUOTE_BYTE;
        2: b = CR_BYTE;
        3: b = LF_BYTE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_word(b, $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic write_delimiter(input logic [7:0] d);
    gen_delim = d;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (words_taken < words_pushed || token_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    string       dir_text;
    int unsigned chunk;
    dir_text = "\"x\"\"y\"z,,\r\n\na\"\r\"p\r\n\"\n\"";
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_delimiter(COMMA_BYTE);
    for (int i = 0; i < dir_text.len(); i++) push_word(dir_text[i], 1'b0);
    push_word(8'h00, 1'b0);
    push_word(QUOTE_BYTE, 1'b0);
    push_word(8'hFF, 1'b1);
    wait_drained();

    foreach (phase_delims[p]) begin
      write_delimiter(phase_delims[p]);
      chunk = words_pushed;
      while (words_pushed - chunk < PHASE_BYTES) begin
        if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 6));
        else push_text($urandom_range(1, 3));
      end
      wait_drained();
    end

    $display("sent %0d text bytes under %0d delimiter writes; %0d tokens compared, %0d mismatches",
             words_taken, settings_used, tokens_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/csvt_pkg.sv
rtl/csv_stream_tokenizer.sv
tb/sv/tb_csv_stream_tokenizer.sv
